FILE: design/cbvf_pkg.sv
`default_nettype none
package cbvf_pkg;

    // Sizing
    localparam int MAX_BOXES  = 64;
    localparam int NUM_BINS   = 20;
    localparam int COORD_BITS = 12;

    localparam int DIM_W     = COORD_BITS + 1;
    localparam int CFG_W     = 13;
    localparam int DIV_W     = (DIM_W > CFG_W) ? DIM_W : CFG_W;
    localparam int BIN_W     = (NUM_BINS > 2) ? $clog2(NUM_BINS) : 1;
    localparam int REM_W     = DIV_W + BIN_W;
    localparam int STEP_W    = $clog2(BIN_W + 1);
    localparam int CNT_W     = $clog2(MAX_BOXES + 1);
    localparam int ADDR_W    = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int SUM_W     = DIV_W + 2;
    localparam int OUT_IDX_W = 6;
    localparam int VOTE_W    = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [VOTE_W-1:0] VOTE_MAX = '1;
    localparam int HEIGHT_SHIFT = 5;    // image height / 32
    localparam int RATIO_MAX    = 4;    // h / w limit
    localparam int BORDER_PAD   = 4;
    localparam int EDGE_MIN     = 2;

    localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b1;

    // Input actions
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EVAL = 1'b1;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [DIM_W-1:0]      w;
        logic [DIM_W-1:0]      h;
    } t_box;

    typedef struct packed {
        logic                  found;
        logic [OUT_IDX_W-1:0]  idx;
        logic [COORD_BITS-1:0] cx;
        logic [COORD_BITS-1:0] cy;
        logic [DIM_W-1:0]      cw;
        logic [DIM_W-1:0]      ch;
        logic                  last;
    } t_res;

    typedef struct packed {
        logic cap_in;
        logic store_wr;
        logic div_start;
        logic div_y;
        logic lat_hb;
        logic lat_tb;
        logic vote;
        logic scan_clr;
        logic scan_step;
        logic walk_clr;
        logic walk_step;
        logic box_rd;
        logic emit;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic basic_ok;
        logic ratio_ok;
        logic div_done;
        logic scan_last;
        logic walk_end;
        logic near_ok;
        logic pend_v;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

FILE: design/cbvf_div.sv
`default_nettype none
module cbvf_div
    import cbvf_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DIV_W-1:0] i_num,
    input  wire logic [DIV_W-1:0] i_den,
    output logic                  o_done,
    output logic [BIN_W-1:0]      o_quo
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [REM_W-1:0]  r_rem;
    logic [REM_W-1:0]  r_trial;
    logic [BIN_W-1:0]  r_quo;
    logic              n_bit;

    assign n_bit = (r_rem >= r_trial);

    // Control: clamp at once when num >= den, else one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (i_num >= i_den) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_step <= STEP_W'(BIN_W - 1);
                end
            end else if (r_busy) begin
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
        end
    end

    // Datapath: restoring division of NUM_BINS*num by den
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            if (i_num >= i_den) begin
                r_quo <= BIN_W'(NUM_BINS - 1);
            end else begin
                r_quo   <= '0;
                r_rem   <= REM_W'(i_num) * REM_W'(NUM_BINS);
                r_trial <= REM_W'(i_den) << (BIN_W - 1);
            end
        end else if (r_busy) begin
            if (n_bit) begin
                r_rem <= r_rem - r_trial;
            end
            r_quo   <= BIN_W'({r_quo, n_bit});
            r_trial <= r_trial >> 1;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule
`default_nettype wire

FILE: design/cbvf_datapath.sv
`default_nettype none
module cbvf_datapath
    import cbvf_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [COORD_BITS-1:0] i_box_x,
    input  wire logic [COORD_BITS-1:0] i_box_y,
    input  wire logic [DIM_W-1:0]      i_box_w,
    input  wire logic [DIM_W-1:0]      i_box_h,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_W-1:0]      i_cfg_data,
    input  wire t_cmd                  i_cmd,
    output t_status                    o_stat,
    input  wire logic                  i_out_ready,
    output logic                       o_out_valid,
    output t_res                       o_res
);

    logic [CFG_W-1:0]  r_img_h;
    logic [CFG_W-1:0]  r_img_w;
    logic [CFG_W-1:0]  eff_h;

    t_box              r_mem [MAX_BOXES];
    t_box              r_box;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_walk;

    logic [VOTE_W-1:0] r_hv [NUM_BINS];
    logic [VOTE_W-1:0] r_tv [NUM_BINS];
    logic [BIN_W-1:0]  hidx;
    logic [BIN_W-1:0]  tidx;
    logic [VOTE_W-1:0] hv_rd;
    logic [VOTE_W-1:0] tv_rd;

    logic [BIN_W-1:0]  r_scan;
    logic [VOTE_W-1:0] r_hbest;
    logic [VOTE_W-1:0] r_tbest;
    logic [BIN_W-1:0]  r_hpk;
    logic [BIN_W-1:0]  r_tpk;
    logic [BIN_W-1:0]  r_hb;
    logic [BIN_W-1:0]  r_tb;

    logic [DIV_W-1:0]  div_num;
    logic              div_done;
    logic [BIN_W-1:0]  div_quo;

    logic [DIV_W-1:0]  h_e;
    logic [DIV_W-1:0]  w_e;
    logic [DIV_W-1:0]  thr;
    logic [DIM_W+2:0]  w5;
    logic              basic_ok;
    logic              ratio_ok;
    logic              near_ok;

    logic [SUM_W-1:0]  sum_xw;
    logic [SUM_W-1:0]  sum_yh;
    logic              keep_box;
    t_res              crop;

    t_res              r_pend;
    logic              r_pend_v;
    logic [OUT_IDX_W-1:0] r_cand;
    t_res              r_out;
    logic              r_out_v;
    logic              out_free;

    function automatic logic near_bin(input logic [BIN_W-1:0] a, input logic [BIN_W-1:0] b);
        logic [BIN_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return (d <= BIN_W'(1));
    endfunction

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_h <= HEIGHT_RESET;
            r_img_w <= WIDTH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HEIGHT: r_img_h <= i_cfg_data;
                CFG_WIDTH:  r_img_w <= i_cfg_data;
            endcase
        end
    end

    assign eff_h = (r_img_h == '0) ? CFG_W'(1) : r_img_h;

    // Box store and working box register
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_wr) begin
            r_mem[r_count[ADDR_W-1:0]] <= r_box;
        end
        if (i_cmd.cap_in) begin
            r_box <= '{x: i_box_x, y: i_box_y, w: i_box_w, h: i_box_h};
        end else if (i_cmd.box_rd) begin
            r_box <= r_mem[r_walk[ADDR_W-1:0]];
        end
    end

    // Fill count and walk pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_walk  <= '0;
        end else begin
            if (i_cmd.fin) begin
                r_count <= '0;
            end else if (i_cmd.store_wr) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.walk_clr) begin
                r_walk <= '0;
            end else if (i_cmd.walk_step) begin
                r_walk <= r_walk + 1'b1;
            end
        end
    end

    // Box tests
    assign h_e      = DIV_W'(r_box.h);
    assign w_e      = DIV_W'(r_box.w);
    assign thr      = DIV_W'(eff_h) >> HEIGHT_SHIFT;
    assign basic_ok = (h_e > thr) && (h_e >= w_e) && (w_e != '0) && (h_e != '0);
    assign w5       = (DIM_W + 3)'(r_box.w) * (DIM_W + 3)'(RATIO_MAX + 1);
    assign ratio_ok = ((DIM_W + 3)'(r_box.h) < w5);
    assign near_ok  = near_bin(r_hb, r_hpk) && near_bin(r_tb, r_tpk);

    // Bin divider, shared by height and top edge
    assign div_num = i_cmd.div_y ? DIV_W'(r_box.y) : h_e;

    cbvf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (DIV_W'(eff_h)),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.lat_hb) begin
            r_hb <= div_quo;
        end
        if (i_cmd.lat_tb) begin
            r_tb <= div_quo;
        end
    end

    // Histograms: one read index each, shared by voting and peak scan
    assign hidx  = i_cmd.vote ? r_hb : r_scan;
    assign tidx  = i_cmd.vote ? r_tb : r_scan;
    assign hv_rd = r_hv[hidx];
    assign tv_rd = r_tv[tidx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.fin) begin
            for (int k = 0; k < NUM_BINS; k++) begin
                r_hv[k] <= '0;
                r_tv[k] <= '0;
            end
        end else if (i_cmd.vote) begin
            if (hv_rd != VOTE_MAX) begin
                r_hv[r_hb] <= hv_rd + 1'b1;
            end
            if (tv_rd != VOTE_MAX) begin
                r_tv[r_tb] <= tv_rd + 1'b1;
            end
        end
    end

    // Peak scan, one bin per cycle, first maximum wins
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.scan_clr) begin
            r_scan  <= '0;
            r_hbest <= '0;
            r_tbest <= '0;
            r_hpk   <= '0;
            r_tpk   <= '0;
        end else if (i_cmd.scan_step) begin
            if (hv_rd > r_hbest) begin
                r_hbest <= hv_rd;
                r_hpk   <= r_scan;
            end
            if (tv_rd > r_tbest) begin
                r_tbest <= tv_rd;
                r_tpk   <= r_scan;
            end
            r_scan <= r_scan + 1'b1;
        end
    end

    // Crop rectangle: widen by one pixel unless near the border
    assign sum_xw   = SUM_W'(r_box.x) + SUM_W'(r_box.w) + SUM_W'(BORDER_PAD);
    assign sum_yh   = SUM_W'(r_box.y) + SUM_W'(r_box.h) + SUM_W'(BORDER_PAD);
    assign keep_box = (sum_xw > SUM_W'(r_img_w)) || (sum_yh > SUM_W'(eff_h)) ||
                      (r_box.x < COORD_BITS'(EDGE_MIN)) || (r_box.y < COORD_BITS'(EDGE_MIN));

    always_comb begin
        crop.found = 1'b1;
        crop.idx   = r_cand;
        crop.last  = 1'b0;
        if (keep_box) begin
            crop.cx = r_box.x;
            crop.cy = r_box.y;
            crop.cw = r_box.w;
            crop.ch = r_box.h;
        end else begin
            crop.cx = r_box.x - 1'b1;
            crop.cy = r_box.y - 1'b1;
            crop.cw = r_box.w + DIM_W'(2);
            crop.ch = r_box.h + DIM_W'(2);
        end
    end

    // Pending result: held back one so the final one can carry last
    assign out_free = !r_out_v || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_cand   <= '0;
        end else if (i_cmd.fin) begin
            r_pend_v <= 1'b0;
            r_cand   <= '0;
        end else if (i_cmd.emit) begin
            r_pend_v <= 1'b1;
            r_cand   <= r_cand + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_pend <= crop;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if ((i_cmd.emit && r_pend_v) || i_cmd.fin) begin
            r_out_v <= 1'b1;
        end else if (i_out_ready) begin
            r_out_v <= 1'b0;
        end
    end

    // Mark the closing result; last is the low bit of the result
    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            if (r_pend_v) begin
                r_out <= {r_pend[$bits(t_res)-1:1], 1'b1};
            end else begin
                r_out <= {{($bits(t_res)-1){1'b0}}, 1'b1};
            end
        end else if (i_cmd.emit && r_pend_v) begin
            r_out <= r_pend;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_res       = r_out;

    // Status toward the controller
    assign o_stat.full      = (r_count >= CNT_W'(MAX_BOXES));
    assign o_stat.basic_ok  = basic_ok;
    assign o_stat.ratio_ok  = ratio_ok;
    assign o_stat.div_done  = div_done;
    assign o_stat.scan_last = (r_scan == BIN_W'(NUM_BINS - 1));
    assign o_stat.walk_end  = (r_walk >= r_count);
    assign o_stat.near_ok   = near_ok;
    assign o_stat.pend_v    = r_pend_v;
    assign o_stat.out_free  = out_free;

endmodule
`default_nettype wire

FILE: design/cbvf_ctrl.sv
`default_nettype none
module cbvf_ctrl
    import cbvf_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_action,
    output logic         o_in_ready,
    input  wire t_status i_stat,
    output t_cmd         o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_LOAD   = 4'd1;
    localparam logic [3:0] S_LDIV_H = 4'd2;
    localparam logic [3:0] S_LDIV_Y = 4'd3;
    localparam logic [3:0] S_VOTE   = 4'd4;
    localparam logic [3:0] S_PEAK   = 4'd5;
    localparam logic [3:0] S_RD     = 4'd6;
    localparam logic [3:0] S_CHK    = 4'd7;
    localparam logic [3:0] S_EDIV_H = 4'd8;
    localparam logic [3:0] S_EDIV_Y = 4'd9;
    localparam logic [3:0] S_SEL    = 4'd10;
    localparam logic [3:0] S_EMIT   = 4'd11;
    localparam logic [3:0] S_FIN    = 4'd12;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // Sequence loads and evaluations
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap_in = 1'b1;
                    if (i_action == ACT_EVAL) begin
                        o_cmd.scan_clr = 1'b1;
                        n_state        = S_PEAK;
                    end else begin
                        n_state = S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                n_state = S_IDLE;
                if (!i_stat.full) begin
                    o_cmd.store_wr = 1'b1;
                    if (i_stat.basic_ok) begin
                        o_cmd.div_start = 1'b1;
                        n_state         = S_LDIV_H;
                    end
                end
            end
            S_LDIV_H: begin
                if (i_stat.div_done) begin
                    o_cmd.lat_hb    = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_y     = 1'b1;
                    n_state         = S_LDIV_Y;
                end
            end
            S_LDIV_Y: begin
                if (i_stat.div_done) begin
                    o_cmd.lat_tb = 1'b1;
                    n_state      = S_VOTE;
                end
            end
            S_VOTE: begin
                o_cmd.vote = 1'b1;
                n_state    = S_IDLE;
            end
            S_PEAK: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_last) begin
                    o_cmd.walk_clr = 1'b1;
                    n_state        = S_RD;
                end
            end
            S_RD: begin
                if (i_stat.walk_end) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.box_rd = 1'b1;
                    n_state      = S_CHK;
                end
            end
            S_CHK: begin
                if (i_stat.basic_ok && i_stat.ratio_ok) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_EDIV_H;
                end else begin
                    o_cmd.walk_step = 1'b1;
                    n_state         = S_RD;
                end
            end
            S_EDIV_H: begin
                if (i_stat.div_done) begin
                    o_cmd.lat_hb    = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_y     = 1'b1;
                    n_state         = S_EDIV_Y;
                end
            end
            S_EDIV_Y: begin
                if (i_stat.div_done) begin
                    o_cmd.lat_tb = 1'b1;
                    n_state      = S_SEL;
                end
            end
            S_SEL: begin
                if (i_stat.near_ok) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.walk_step = 1'b1;
                    n_state         = S_RD;
                end
            end
            S_EMIT: begin
                if (!i_stat.pend_v || i_stat.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.walk_step = 1'b1;
                    n_state         = S_RD;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

FILE: design/character_box_vote_filter_top.sv
// Load: a box that is dropped or fails the basic test ends without a division; one that
//   votes takes two bin divisions on the shared divider, then the vote.
// Evaluate: take the item and scan the peaks, then check each stored box, then close;
//   output backpressure stalls the box walk.
// Synchronous active-low reset clears the controller, counts, histograms and the
//   output; config returns to 480 x 640. The box store is not cleared.
`default_nettype none
module character_box_vote_filter_top
    import cbvf_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic                  i_action,
    input  wire logic [COORD_BITS-1:0] i_box_x,
    input  wire logic [COORD_BITS-1:0] i_box_y,
    input  wire logic [DIM_W-1:0]      i_box_w,
    input  wire logic [DIM_W-1:0]      i_box_h,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic                       o_found,
    output logic [OUT_IDX_W-1:0]       o_candidate_index,
    output logic [COORD_BITS-1:0]      o_crop_x,
    output logic [COORD_BITS-1:0]      o_crop_y,
    output logic [DIM_W-1:0]           o_crop_w,
    output logic [DIM_W-1:0]           o_crop_h,
    output logic                       o_last,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_W-1:0]      i_cfg_data
);

    t_cmd    cmd;
    t_status stat;
    t_res    res;

    // Config writes are always accepted and registered
    assign o_cfg_ready = 1'b1;

    cbvf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_action),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    cbvf_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_box_x     (i_box_x),
        .i_box_y     (i_box_y),
        .i_box_w     (i_box_w),
        .i_box_h     (i_box_h),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_res       (res)
    );

    assign o_found           = res.found;
    assign o_candidate_index = res.idx;
    assign o_crop_x          = res.cx;
    assign o_crop_y          = res.cy;
    assign o_crop_w          = res.cw;
    assign o_crop_h          = res.ch;
    assign o_last            = res.last;

endmodule
`default_nettype wire

FILE: design/cbvf_checker.sv
`default_nettype none
module cbvf_checker
    import cbvf_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_in_valid,
    input wire logic                  o_in_ready,
    input wire logic                  i_action,
    input wire logic [COORD_BITS-1:0] i_box_x,
    input wire logic [COORD_BITS-1:0] i_box_y,
    input wire logic [DIM_W-1:0]      i_box_w,
    input wire logic [DIM_W-1:0]      i_box_h,
    input wire logic                  o_out_valid,
    input wire logic                  i_out_ready,
    input wire logic                  o_found,
    input wire logic [OUT_IDX_W-1:0]  o_candidate_index,
    input wire logic [COORD_BITS-1:0] o_crop_x,
    input wire logic [COORD_BITS-1:0] o_crop_y,
    input wire logic [DIM_W-1:0]      o_crop_w,
    input wire logic [DIM_W-1:0]      o_crop_h,
    input wire logic                  o_last,
    input wire logic                  i_cfg_valid,
    input wire logic                  o_cfg_ready,
    input wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input wire logic [CFG_W-1:0]      i_cfg_data
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_crop_x) &&
        $stable(o_crop_y) && $stable(o_candidate_index) && $stable(o_last))
        else $error("result changed while stalled");

    // Reset empties the output
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A not-found result is the closing one, with zero index, width and height
    a_none_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_last && (o_candidate_index == '0) &&
        (o_crop_w == '0) && (o_crop_h == '0))
        else $error("empty result malformed");

    // After a non-final transfer the next result is a found crop
    a_no_empty_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last |=> !(o_out_valid && !o_found))
        else $error("empty result inside an evaluation");

endmodule

bind character_box_vote_filter_top cbvf_checker u_cbvf_checker (.*);
`default_nettype wire

FILE: tb/sv/tb_character_box_vote_filter_top.sv
`default_nettype none
module tb_character_box_vote_filter_top;
    import cbvf_pkg::*;

    typedef struct packed {
        logic                  action;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [DIM_W-1:0]      w;
        logic [DIM_W-1:0]      h;
    } t_item;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_action = 1'b0;
    logic [COORD_BITS-1:0] i_box_x = '0;
    logic [COORD_BITS-1:0] i_box_y = '0;
    logic [DIM_W-1:0]      i_box_w = '0;
    logic [DIM_W-1:0]      i_box_h = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_found;
    logic [OUT_IDX_W-1:0]  o_candidate_index;
    logic [COORD_BITS-1:0] o_crop_x;
    logic [COORD_BITS-1:0] o_crop_y;
    logic [DIM_W-1:0]      o_crop_w;
    logic [DIM_W-1:0]      o_crop_h;
    logic                  o_last;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_HEIGHT;
    logic [CFG_W-1:0]      i_cfg_data = '0;

    character_box_vote_filter_top DUT (.*);

    // Clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state
    int unsigned img_h, img_w, n_boxes;
    t_box        boxes[MAX_BOXES];
    int unsigned h_votes[NUM_BINS];
    int unsigned t_votes[NUM_BINS];
    t_res        crop_q[$];
    t_item       pend_q[$];

    int  errors = 0;
    int  stall_pct = 18;
    int  idle_cnt = 0;

    function automatic int unsigned eff_h();
        return (img_h == 0) ? 1 : img_h;
    endfunction

    function automatic int unsigned bin_of(int unsigned v);
        int unsigned b;
        b = (NUM_BINS * v) / eff_h();
        return (b >= NUM_BINS) ? NUM_BINS - 1 : b;
    endfunction

    function automatic bit passes_basic(t_box b);
        return b.h > eff_h() / 32 && b.h >= b.w && b.w > 0 && b.h > 0;
    endfunction

    function automatic int unsigned peak_bin(int unsigned hist[NUM_BINS]);
        int unsigned best, idx;
        best = 0;
        idx = 0;
        for (int i = 0; i < NUM_BINS; i++)
            if (hist[i] > best) begin
                best = hist[i];
                idx = i;
            end
        return idx;
    endfunction

    function automatic bit near(int unsigned a, int unsigned b);
        return ((a > b) ? a - b : b - a) <= 1;
    endfunction

    function automatic void clear_votes();
        n_boxes = 0;
        for (int i = 0; i < NUM_BINS; i++) begin
            h_votes[i] = 0;
            t_votes[i] = 0;
        end
    endfunction

    // Load a box or evaluate the store, queuing expected crops
    function automatic void predict_crops(t_item it);
        t_box        b;
        t_res        r;
        int unsigned hp, tp, n, hb, tb;
        if (it.action == ACT_LOAD) begin
            if (n_boxes >= MAX_BOXES) return;
            b = '{x: it.x, y: it.y, w: it.w, h: it.h};
            boxes[n_boxes] = b;
            n_boxes++;
            if (passes_basic(b)) begin
                hb = bin_of(b.h);
                tb = bin_of(b.y);
                if (h_votes[hb] < 127) h_votes[hb]++;
                if (t_votes[tb] < 127) t_votes[tb]++;
            end
            return;
        end
        hp = peak_bin(h_votes);
        tp = peak_bin(t_votes);
        n = 0;
        for (int i = 0; i < n_boxes; i++) begin
            b = boxes[i];
            if (!passes_basic(b)) continue;
            if (b.h / b.w > 4) continue;
            if (!near(bin_of(b.h), hp) || !near(bin_of(b.y), tp)) continue;
            r = '0;
            r.found = 1'b1;
            r.idx = n[OUT_IDX_W-1:0];
            if (32'(b.x) + b.w + 4 > img_w || 32'(b.y) + b.h + 4 > eff_h()
                    || b.x < 2 || b.y < 2) begin
                r.cx = b.x; r.cy = b.y; r.cw = b.w; r.ch = b.h;
            end else begin
                r.cx = b.x - 1'b1; r.cy = b.y - 1'b1;
                r.cw = b.w + 2'd2; r.ch = b.h + 2'd2;
            end
            crop_q = {crop_q, r};
            n++;
        end
        if (n == 0) begin
            r = '0;
            r.last = 1'b1;
            crop_q = {crop_q, r};
        end else begin
            crop_q[$].last = 1'b1;
        end
        clear_votes();
    endfunction

    // Driver: present pending items, advance on transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                predict_crops('{i_action, i_box_x, i_box_y, i_box_w, i_box_h});
                void'(pend_q.pop_front());
            end
            if (!(i_in_valid && !o_in_ready)) begin
                if (pend_q.size() > 0 && $urandom_range(99) >= stall_pct) begin
                    t_item nx;
                    nx = pend_q[0];
                    i_in_valid <= 1'b1;
                    {i_action, i_box_x, i_box_y, i_box_w, i_box_h} <= nx;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Monitor: compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_res got, want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_found, o_candidate_index, o_crop_x, o_crop_y,
                    o_crop_w, o_crop_h, o_last};
            if (crop_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected crop %p", got);
            end else begin
                want = crop_q.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10) $display("crop mismatch exp %p got %p", want, got);
                end
            end
        end
    end

    // Watchdog: count cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt > 20000) begin
            $display("tb_character_box_vote_filter_top: errors");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pend_q.size() != 0 || crop_q.size() != 0 || i_in_valid)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // Start on a fresh edge so back-to-back writes never overlap
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val[CFG_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_HEIGHT) img_h = val & 13'h1FFF;
        else img_w = val & 13'h1FFF;
    endtask

    function automatic void push_box(int unsigned x, int unsigned y,
                                     int unsigned w, int unsigned h);
        t_item it;
        it = '{ACT_LOAD, x[COORD_BITS-1:0], y[COORD_BITS-1:0],
               w[DIM_W-1:0], h[DIM_W-1:0]};
        pend_q = {pend_q, it};
    endfunction

    function automatic void push_eval();
        t_item it;
        it = '0;
        it.action = ACT_EVAL;
        it.x = COORD_BITS'($urandom);
        it.y = COORD_BITS'($urandom);
        pend_q = {pend_q, it};
    endfunction

    // Build a random box, mostly character-like and scaled to the current image
    function automatic void push_char_box();
        int unsigned hh, h, w, y, x;
        hh = eff_h();
        case ($urandom_range(9))
            0: push_box($urandom, $urandom, $urandom_range(4096), $urandom_range(4096));
            1: push_box($urandom, $urandom, 0, $urandom_range(4096));
            default: begin
                h = hh / 32 + 1 + $urandom_range(hh / 8 + 2);
                w = 1 + $urandom_range(h - 1);
                y = $urandom_range(hh);
                x = $urandom_range((img_w > 0) ? img_w : 1);
                if (h > 4096) h = 4096;
                if (w > h) w = h;
                push_box(x % 4096, y % 4096, w, h);
            end
        endcase
    endfunction

    task automatic random_phase(int unsigned n);
        int unsigned k;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(11) == 0) begin
                k = 62 + $urandom_range(4);
                for (int j = 0; j < k; j++) push_char_box();
            end else begin
                k = $urandom_range(8);
                for (int j = 0; j < k; j++) push_char_box();
            end
            push_eval();
        end
        wait_drained();
    endtask

    initial begin
        img_h = HEIGHT_RESET;
        img_w = WIDTH_RESET;
        clear_votes();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: nothing stored, extremes, crop border rules, ties
        push_eval();
        push_box(100, 100, 10, 30);
        push_box(1, 100, 10, 30);
        push_box(100, 1, 10, 30);
        push_box(620, 100, 10, 30);
        push_box(100, 440, 10, 30);
        push_box(100, 100, 5, 30);
        push_box(100, 100, 30, 10);
        push_box(100, 100, 0, 0);
        push_box(4095, 4095, 4096, 4096);
        push_box(0, 0, 1, 16);
        push_box(200, 479, 12, 480);
        push_eval();
        push_box(4095, 4095, 4096, 4096);
        push_box(0, 0, 1, 4096);
        push_eval();
        stall_pct = 0;
        wait_drained();
        // Full store: the last loads are dropped
        for (int i = 0; i < 66; i++) push_box(10 + i, 50, 8, 20);
        push_eval();
        wait_drained();
        stall_pct = 18;

        // Settings sweep, extremes included
        random_phase(4);
        write_reg(CFG_HEIGHT, 0);
        write_reg(CFG_WIDTH, 0);
        push_box(0, 0, 1, 1);
        push_box(5, 5, 1, 1);
        push_eval();
        random_phase(2);
        write_reg(CFG_HEIGHT, 4096);
        write_reg(CFG_WIDTH, 4096);
        random_phase(3);
        write_reg(CFG_HEIGHT, 1);
        write_reg(CFG_WIDTH, 1);
        random_phase(2);
        write_reg(CFG_HEIGHT, 8191);
        write_reg(CFG_WIDTH, 8191);
        random_phase(2);
        write_reg(CFG_HEIGHT, 64);
        write_reg(CFG_WIDTH, 100);
        random_phase(3);
        write_reg(CFG_HEIGHT, 480);
        write_reg(CFG_WIDTH, 640);
        random_phase(3);

        if (errors == 0)
            $display("tb_character_box_vote_filter_top: clean");
        else
            $display("tb_character_box_vote_filter_top: errors");
        $finish;
    end
endmodule
`default_nettype wire
